// ===== hdl/mlpf_pkg.sv =====
// Shared types and constants for the link packet framer.
// No dependencies; every other file but the checker imports this package.
package mlpf_pkg;

	localparam int UNITS_DEF        = 4;
	localparam int PACKET_WORDS_DEF = 14;
	localparam int OUTQ_DEPTH       = 4;

	localparam logic [1:0] KIND_XFER  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_SWAP  = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic CFG_IS_PARENT = 1'b0;
	localparam logic CFG_SYNC_WORD = 1'b1;

	localparam logic [15:0] SYNC_RESET = 16'hFEFE;

	typedef struct packed {
		logic [1:0]       kind;
		logic [3:0][15:0] recv;
		logic             link_error;
		logic [1:0]       player;
		logic [3:0]       word_index;
		logic [15:0]      write_data;
	} item_t;

	typedef struct packed {
		logic xfer;
		logic wr;
		logic swap;
		logic rd;
	} op_t;

	typedef struct packed {
		logic [15:0] send_word;
		logic        send_valid;
		logic        hard_error;
		logic        rearm;
		logic [3:0]  landed_flags;
		logic [15:0] read_data;
	} result_t;

endpackage

// ===== hdl/mlpf_front.sv =====
// Front end: two-entry input queue and kind decode.
// Depends on mlpf_pkg.
module mlpf_front import mlpf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t in_item,
	output logic  full,
	output logic  q_valid,
	output item_t q_item,
	output op_t   q_op,
	input  logic  q_pop
);

	item_t      ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;
	assign q_item  = ent_q[rd_ptr_q];

	always_comb begin
		q_op = '0;
		unique case (q_item.kind)
			KIND_XFER:  q_op.xfer = 1'b1;
			KIND_WRITE: q_op.wr   = 1'b1;
			KIND_SWAP:  q_op.swap = 1'b1;
			KIND_READ:  q_op.rd   = 1'b1;
			default:    q_op      = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== hdl/mlpf_back.sv =====
// Back end: send and receive buffers, counters, config registers, result build.
// Depends on mlpf_pkg.
module mlpf_back import mlpf_pkg::*; #(
	parameter int UNITS        = UNITS_DEF,
	parameter int PACKET_WORDS = PACKET_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	input  op_t         q_op,
	output logic        q_pop,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [2:0]  out_count,
	output logic        res_valid,
	output result_t     res
);

	localparam int PW_W = $clog2(PACKET_WORDS) + 1;
	localparam int IW   = $clog2(PACKET_WORDS);
	localparam int SAW  = $clog2(2 * PACKET_WORDS);
	localparam int RAW  = $clog2(3 * PACKET_WORDS);
	localparam int UW   = $clog2(UNITS);
	localparam logic signed [PW_W-1:0] POS_LAST = PW_W'(PACKET_WORDS - 1);
	localparam logic signed [PW_W-1:0] POS_DONE = PW_W'(PACKET_WORDS - 3);
	localparam logic signed [PW_W-1:0] POS_NONE = '1;
	localparam logic signed [PW_W-1:0] POS_ZERO = '0;

	logic        is_parent_q;
	logic [15:0] sync_q;
	logic        err_q;
	logic        send_sel_q;
	logic signed [PW_W-1:0] send_pos_q;
	logic [15:0] send_mem [2*PACKET_WORDS];

	logic        fire;
	logic        widx_ok;
	logic [IW-1:0] widx;
	logic [UNITS-1:0] unit_flags;
	logic [15:0] unit_rd_q [UNITS];

	logic        v_s2, xfer_s2, sync_hit_s2, err_s2, rearm_s2, rd_s2;
	logic [15:0] sync_s2, send_rd_s2;
	logic [3:0]  landed_s2;
	logic [1:0]  player_s2;

	// advance only when the output queue has room for this word and the one in s2
	assign fire    = q_valid && ((out_count + 3'(v_s2)) < 3'(OUTQ_DEPTH));
	assign q_pop   = fire;
	assign widx_ok = (32'(q_item.word_index) < PACKET_WORDS);
	assign widx    = IW'(q_item.word_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_parent_q <= 1'b0;
			sync_q      <= SYNC_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IS_PARENT: is_parent_q <= cfg_data[0];
				CFG_SYNC_WORD: sync_q      <= cfg_data;
				default:       sync_q      <= sync_q;
			endcase
		end
	end

	// send side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_sel_q <= 1'b0;
			send_pos_q <= POS_NONE;
			err_q      <= 1'b0;
		end else if (fire && q_op.xfer) begin
			err_q <= q_item.link_error;
			if (send_pos_q < POS_ZERO) begin
				send_sel_q <= ~send_sel_q;
			end
			if (send_pos_q < POS_LAST) begin
				send_pos_q <= send_pos_q + PW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && q_op.wr && widx_ok) begin
			send_mem[SAW'(send_sel_q ? 1'b0 : 1'b1) * SAW'(PACKET_WORDS) + SAW'(widx)]
				<= q_item.write_data;
		end
		if (fire && q_op.xfer && send_pos_q >= POS_ZERO) begin
			send_rd_s2 <= send_mem[SAW'(send_sel_q) * SAW'(PACKET_WORDS)
				+ SAW'(send_pos_q[IW-1:0])];
		end
	end

	// receive side, one lane per unit
	for (genvar u = 0; u < UNITS; u++) begin : g_unit
		logic signed [PW_W-1:0] pos_q;
		logic [1:0]  fill_q, comp_q, insp_q;
		logic        flag_q;
		logic [15:0] rmem [3*PACKET_WORDS];
		logic [15:0] w;
		logic        realign, wr_en, done;
		logic [IW-1:0] pos0;

		assign w       = q_item.recv[u];
		assign realign = (w == sync_q) && (pos_q > POS_DONE);
		assign pos0    = (pos_q < POS_ZERO) ? '0 : pos_q[IW-1:0];
		assign wr_en   = fire && q_op.xfer && !realign;
		assign done    = wr_en && (PW_W'(pos0) == POS_DONE);
		assign unit_flags[u] = flag_q;

		always_ff @(posedge clk) begin
			if (wr_en) begin
				rmem[RAW'(fill_q) * RAW'(PACKET_WORDS) + RAW'(pos0)] <= w;
			end
			if (fire && q_op.rd && widx_ok) begin
				unit_rd_q[u] <= rmem[RAW'(insp_q) * RAW'(PACKET_WORDS) + RAW'(widx)];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q  <= POS_LAST;
				fill_q <= 2'd0;
				comp_q <= 2'd1;
				insp_q <= 2'd2;
				flag_q <= 1'b0;
			end else if (fire) begin
				if (q_op.xfer) begin
					if (realign) begin
						pos_q <= POS_ZERO;
					end else if (pos_q < POS_LAST) begin
						pos_q <= pos_q + PW_W'(1);
					end
					if (done) begin
						comp_q <= fill_q;
						fill_q <= comp_q;
						flag_q <= 1'b1;
					end
				end else if (q_op.swap) begin
					insp_q <= comp_q;
					comp_q <= insp_q;
					flag_q <= 1'b0;
				end
			end
		end
	end

	// stage 2 control and captured fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			xfer_s2     <= q_op.xfer;
			sync_hit_s2 <= (send_pos_q < POS_ZERO);
			sync_s2     <= sync_q;
			err_s2      <= q_op.xfer ? q_item.link_error : err_q;
			rearm_s2    <= q_op.xfer && is_parent_q;
			landed_s2   <= q_op.swap ? 4'(unit_flags) : 4'd0;
			rd_s2       <= q_op.rd && widx_ok && (32'(q_item.player) < UNITS);
			player_s2   <= q_item.player;
		end
	end

	assign res_valid        = v_s2;
	assign res.send_word    = !xfer_s2 ? 16'd0 : (sync_hit_s2 ? sync_s2 : send_rd_s2);
	assign res.send_valid   = xfer_s2;
	assign res.hard_error   = err_s2;
	assign res.rearm        = rearm_s2;
	assign res.landed_flags = landed_s2;
	assign res.read_data    = rd_s2 ? unit_rd_q[player_s2[UW-1:0]] : 16'd0;

endmodule

// ===== hdl/mlpf_outq.sv =====
// Result queue between the back end and the result ports.
// Depends on mlpf_pkg.
module mlpf_outq import mlpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	input  result_t    wr_data,
	output logic [2:0] count,
	output logic       empty,
	input  logic       pop,
	output result_t    head
);

	localparam int PTR_W = $clog2(OUTQ_DEPTH);

	result_t         ent_q [OUTQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0]       count_q;
	logic             do_pop;

	assign count  = count_q;
	assign empty  = (count_q == 3'd0);
	assign do_pop = pop && !empty;
	assign head   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + 3'(wr_valid) - 3'(do_pop);
		end
	end

endmodule

// ===== hdl/multiplayer_link_packet_framer.sv =====
// channel   direction  handshake           payload
// input     in         push / full         kind, recv_word_0..3, link_error, player,
//                                          word_index, write_data
// result    out        empty / pop         send_word, send_valid, hard_error, rearm,
//                                          landed_flags, read_data
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while the result ports are popped; a result reaches
// the result ports through the input queue, the execute stage with the buffer memory
// read, then the result queue.
// Reset clears counters, buffer ids, flags and queues; buffer contents are kept.
// A stalled pop backs up through the four-entry result queue, then the input queue.
// Top level; depends on mlpf_pkg, mlpf_front, mlpf_back, mlpf_outq.
module multiplayer_link_packet_framer import mlpf_pkg::*; #(
	parameter int UNITS        = UNITS_DEF,
	parameter int PACKET_WORDS = PACKET_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [15:0] recv_word_0,
	input  logic [15:0] recv_word_1,
	input  logic [15:0] recv_word_2,
	input  logic [15:0] recv_word_3,
	input  logic        link_error,
	input  logic [1:0]  player,
	input  logic [3:0]  word_index,
	input  logic [15:0] write_data,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] send_word,
	output logic        send_valid,
	output logic        hard_error,
	output logic        rearm,
	output logic [3:0]  landed_flags,
	output logic [15:0] read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	item_t      in_item, q_item;
	op_t        q_op;
	logic       q_valid, q_pop, res_valid;
	result_t    res, head;
	logic [2:0] out_count;

	assign cfg_ready = 1'b1;

	assign in_item.kind       = kind;
	assign in_item.recv       = {recv_word_3, recv_word_2, recv_word_1, recv_word_0};
	assign in_item.link_error = link_error;
	assign in_item.player     = player;
	assign in_item.word_index = word_index;
	assign in_item.write_data = write_data;

	mlpf_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(in_item), .full(full),
		.q_valid(q_valid), .q_item(q_item), .q_op(q_op), .q_pop(q_pop)
	);

	mlpf_back #(.UNITS(UNITS), .PACKET_WORDS(PACKET_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_op(q_op),
		.q_pop(q_pop), .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_count(out_count), .res_valid(res_valid), .res(res)
	);

	mlpf_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr_valid(res_valid), .wr_data(res),
		.count(out_count), .empty(empty), .pop(pop), .head(head)
	);

	assign send_word    = head.send_word;
	assign send_valid   = head.send_valid;
	assign hard_error   = head.hard_error;
	assign rearm        = head.rearm;
	assign landed_flags = head.landed_flags;
	assign read_data    = head.read_data;

endmodule

// ===== hdl/mlpf_checker.sv =====
// Port-level checks on the result channel of the framer, bound to the top level.
// Depends only on the top level's ports.
module mlpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] send_word,
	input logic        send_valid,
	input logic        rearm,
	input logic [3:0]  landed_flags,
	input logic [15:0] read_data
);

	a_rearm_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rearm |-> send_valid) else $error("rearm without a send word");

	a_send_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && send_valid |-> landed_flags == 4'd0 && read_data == 16'd0)
		else $error("send word carries swap or read fields");

	a_idle_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !send_valid |-> send_word == 16'd0)
		else $error("send word nonzero outside a transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(send_word) && $stable(read_data))
		else $error("waiting result changed");

endmodule

bind multiplayer_link_packet_framer mlpf_checker u_mlpf_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .send_word(send_word),
	.send_valid(send_valid), .rearm(rearm), .landed_flags(landed_flags),
	.read_data(read_data)
);

// ===== dv/multiplayer_link_packet_framer_tb.sv =====
// Testbench for the link packet framer: queued stimulus, a shadow of the
// framer state that predicts every result word, and a checking monitor.
// Depends on mlpf_pkg and the multiplayer_link_packet_framer RTL.
`timescale 1ns / 1ps

module multiplayer_link_packet_framer_tb;
	import mlpf_pkg::*;

	localparam int NU = 4;
	localparam int NW = 14;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = KIND_XFER;
	logic [15:0] recv_word_0 = '0, recv_word_1 = '0, recv_word_2 = '0, recv_word_3 = '0;
	logic        link_error = 1'b0;
	logic [1:0]  player = '0;
	logic [3:0]  word_index = '0;
	logic [15:0] write_data = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] send_word;
	logic        send_valid, hard_error, rearm;
	logic [3:0]  landed_flags;
	logic [15:0] read_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_IS_PARENT;
	logic [15:0] cfg_data = '0;

	multiplayer_link_packet_framer uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	item_t   words_pending[$];
	result_t results_due[$];
	int      errors = 0;
	int      cycles = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;

	// shadow of the framer
	bit          sh_parent;
	logic [15:0] sh_sync;
	logic [15:0] send_buf[2][NW];
	bit          send_sel;
	int          send_pos;
	logic [15:0] recv_buf[NU][3][NW];
	bit          recv_seen[NU][3][NW];
	int          recv_pos[NU];
	int          fill_id[NU], done_id[NU], look_id[NU];
	bit          landed[NU];
	bit          err_latch;

	// per-unit packet stream state for stimulus
	int stream_cnt[NU];
	int stream_len[NU];

	// advance the shadow by one word and queue the result it yields
	task automatic frame_step(input item_t it);
		result_t r;
		int      t, p;
		logic [15:0] w;
		r = '0;
		case (it.kind)
			KIND_XFER: begin
				err_latch = it.link_error;
				if (send_pos < 0) begin
					r.send_word = sh_sync;
					send_sel ^= 1'b1;
				end else begin
					r.send_word = send_buf[send_sel][send_pos];
				end
				if (send_pos < NW - 1) send_pos++;
				r.send_valid = 1'b1;
				for (int u = 0; u < NU; u++) begin
					w = it.recv[u];
					if (w == sh_sync && recv_pos[u] > NW - 3) begin
						recv_pos[u] = -1;
					end else begin
						p = (recv_pos[u] < 0) ? 0 : recv_pos[u];
						recv_buf[u][fill_id[u]][p] = w;
						recv_seen[u][fill_id[u]][p] = 1'b1;
						if (p == NW - 3) begin
							t = done_id[u];
							done_id[u] = fill_id[u];
							fill_id[u] = t;
							landed[u] = 1'b1;
						end
					end
					if (recv_pos[u] < NW - 1) recv_pos[u]++;
				end
				r.rearm = sh_parent;
			end
			KIND_WRITE: begin
				if (it.word_index < NW) send_buf[~send_sel][it.word_index] = it.write_data;
			end
			KIND_SWAP: begin
				for (int u = 0; u < NU; u++) begin
					t = look_id[u];
					look_id[u] = done_id[u];
					done_id[u] = t;
					r.landed_flags[u] = landed[u];
					landed[u] = 1'b0;
				end
			end
			default: begin
				if (it.word_index < NW)
					r.read_data = recv_buf[it.player][look_id[it.player]][it.word_index];
			end
		endcase
		r.hard_error = err_latch;
		results_due.push_back(r);
		words_pending.push_back(it);
	endtask

	task automatic send_xfer(input logic [15:0] w0, w1, w2, w3, input bit e);
		item_t it;
		it = '0;
		it.kind = KIND_XFER;
		it.recv[0] = w0;
		it.recv[1] = w1;
		it.recv[2] = w2;
		it.recv[3] = w3;
		it.link_error = e;
		it.player = 2'($urandom);
		it.word_index = 4'($urandom);
		it.write_data = 16'($urandom);
		frame_step(it);
	endtask

	task automatic send_other(input logic [1:0] k, input int pl,
			input int idx, input logic [15:0] d);
		item_t it;
		it = '0;
		it.kind = k;
		for (int u = 0; u < NU; u++) it.recv[u] = 16'($urandom);
		it.link_error = 1'($urandom);
		it.player = 2'(pl);
		it.word_index = 4'(idx);
		it.write_data = d;
		frame_step(it);
	endtask

	// read entries that were filled since power-up, or else an out-of-range index
	task automatic send_read();
		int pl, idx;
		bit hit;
		hit = 1'b0;
		for (int tries = 0; tries < 10 && !hit; tries++) begin
			pl = $urandom_range(NU - 1);
			idx = $urandom_range(NW - 1);
			hit = recv_seen[pl][look_id[pl]][idx];
		end
		if (!hit) idx = $urandom_range(15, NW);
		send_other(KIND_READ, pl, idx, 16'($urandom));
	endtask

	task automatic random_xfer();
		logic [15:0] w[NU];
		for (int u = 0; u < NU; u++) begin
			if (stream_cnt[u] == 0) w[u] = sh_sync;
			else if ($urandom_range(99) < 3) w[u] = sh_sync;
			else w[u] = 16'($urandom);
			stream_cnt[u]++;
			if (stream_cnt[u] >= stream_len[u]) begin
				stream_cnt[u] = 0;
				// mostly well-formed packets, now and then a broken one
				stream_len[u] = ($urandom_range(99) < 80) ? NW : $urandom_range(3, 20);
			end
		end
		send_xfer(w[0], w[1], w[2], w[3], $urandom_range(99) < 20);
	endtask

	task automatic cfg_write(input logic idx, input logic [15:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_IS_PARENT) sh_parent = d[0];
		else sh_sync = d;
	endtask

	task automatic drain();
		do @(negedge clk); while (words_pending.size() != 0 || push || results_due.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) void'(words_pending.pop_front());
			if (push && full) begin
				// hold the offered word
			end else if (words_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
				push        <= 1'b1;
				kind        <= words_pending[0].kind;
				recv_word_0 <= words_pending[0].recv[0];
				recv_word_1 <= words_pending[0].recv[1];
				recv_word_2 <= words_pending[0].recv[2];
				recv_word_3 <= words_pending[0].recv[3];
				link_error  <= words_pending[0].link_error;
				player      <= words_pending[0].player;
				word_index  <= words_pending[0].word_index;
				write_data  <= words_pending[0].write_data;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result word send_word=%h", $time, send_word);
					errors++;
				end else begin
					e = results_due.pop_front();
					if (send_word !== e.send_word) begin
						$display("%0t: send_word exp %h got %h", $time, e.send_word, send_word);
						errors++;
					end
					if (send_valid !== e.send_valid) begin
						$display("%0t: send_valid exp %b got %b", $time, e.send_valid, send_valid);
						errors++;
					end
					if (hard_error !== e.hard_error) begin
						$display("%0t: hard_error exp %b got %b", $time, e.hard_error, hard_error);
						errors++;
					end
					if (rearm !== e.rearm) begin
						$display("%0t: rearm exp %b got %b", $time, e.rearm, rearm);
						errors++;
					end
					if (landed_flags !== e.landed_flags) begin
						$display("%0t: landed_flags exp %h got %h", $time, e.landed_flags,
							landed_flags);
						errors++;
					end
					if (read_data !== e.read_data) begin
						$display("%0t: read_data exp %h got %h", $time, e.read_data, read_data);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL multiplayer_link_packet_framer");
			$finish;
		end
	end

	initial begin
		int n, r;
		sh_parent = 1'b0;
		sh_sync = SYNC_RESET;
		send_sel = 1'b0;
		send_pos = -1;
		err_latch = 1'b0;
		for (int u = 0; u < NU; u++) begin
			recv_pos[u] = NW - 1;
			fill_id[u] = 0;
			done_id[u] = 1;
			look_id[u] = 2;
			landed[u] = 1'b0;
			stream_cnt[u] = u;
			stream_len[u] = NW;
			for (int b = 0; b < 3; b++)
				for (int i = 0; i < NW; i++) recv_seen[u][b][i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			cfg_write(CFG_IS_PARENT, 16'(ph[0]));
			case (ph)
				0: cfg_write(CFG_SYNC_WORD, SYNC_RESET);
				1: cfg_write(CFG_SYNC_WORD, 16'h0000);
				2: cfg_write(CFG_SYNC_WORD, 16'hFFFF);
				default: cfg_write(CFG_SYNC_WORD, 16'($urandom));
			endcase
			@(negedge clk);
			if (ph == 0) begin
				// fill the send buffer that the first transfer brings into use
				for (int i = 0; i < NW; i++)
					send_other(KIND_WRITE, 0, i, (i == 0) ? 16'h0000 :
						(i == 1) ? 16'hFFFF : 16'($urandom));
				send_other(KIND_WRITE, 0, 15, 16'hFFFF);
				send_other(KIND_WRITE, 0, NW, 16'h1234);
				send_other(KIND_SWAP, 0, 0, 16'h0000);
				send_other(KIND_READ, 3, 15, 16'h0000);
				send_xfer(sh_sync, sh_sync, sh_sync, sh_sync, 1'b1);
				send_xfer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
				send_xfer(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
				for (int i = 0; i < NW; i++) random_xfer();
				send_other(KIND_SWAP, 0, 0, 16'h0000);
				send_other(KIND_READ, 0, 0, 16'h0000);
				// last word of the completed packet
				send_other(KIND_READ, 3, NW - 3, 16'h0000);
			end
			for (n = 0; n < 300; n++) begin
				r = $urandom_range(99);
				if (r < 62) random_xfer();
				else if (r < 70) send_other(KIND_WRITE, 0, $urandom, 16'($urandom));
				else if (r < 80) send_other(KIND_SWAP, $urandom, $urandom, 16'($urandom));
				else send_read();
			end
		end
		drain();
		if (errors == 0) begin
			$display("PASS multiplayer_link_packet_framer");
		end else begin
			$display("FAIL multiplayer_link_packet_framer");
		end
		$finish;
	end

endmodule
